// ===== sv/prc_pkg.sv =====
// Shared types and constants of the present rate classifier.
`timescale 1ns / 1ps
`default_nettype none

package prc_pkg;

    // Field widths
    localparam int unsigned TIME_W     = 64;
    localparam int unsigned IV_W       = 27;
    localparam int unsigned AVG_W      = IV_W + 3;
    localparam int unsigned COUNT_W    = 7;
    localparam int unsigned RUN_W      = 5;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned APB_ADDR_W = 5;

    // Slow run saturates at the top of its counter
    localparam logic [RUN_W-1:0] SLOW_RUN_MAX = '1;

    // Reset values of the configuration registers
    localparam logic [IV_W-1:0]    RST_MIN_INTERVAL  = 27'd4000000;
    localparam logic [IV_W-1:0]    RST_MAX_INTERVAL  = 27'd100000000;
    localparam logic [IV_W-1:0]    RST_HIGH_RATE_LIM = 27'd30000000;
    localparam logic [IV_W-1:0]    RST_SLOW_INTERVAL = 27'd31500000;
    localparam logic [COUNT_W-1:0] RST_MIN_SAMPLES   = 7'd8;
    localparam logic [RUN_W-1:0]   RST_SLOW_RUN_LIM  = 5'd16;

    // Rate decision codes
    typedef enum logic [1:0] {
        DEC_UND  = 2'd0,
        DEC_LOW  = 2'd1,
        DEC_HIGH = 2'd2
    } t_decision;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_MIN_INTERVAL  = 3'd0,
        REG_MAX_INTERVAL  = 3'd1,
        REG_HIGH_RATE_LIM = 3'd2,
        REG_SLOW_INTERVAL = 3'd3,
        REG_MIN_SAMPLES   = 3'd4,
        REG_SLOW_RUN_LIM  = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [IV_W-1:0]    min_interval_ns;
        logic [IV_W-1:0]    max_interval_ns;
        logic [IV_W-1:0]    high_rate_limit_ns;
        logic [IV_W-1:0]    slow_interval_ns;
        logic [COUNT_W-1:0] min_samples;
        logic [RUN_W-1:0]   slow_run_limit;
    } t_cfg;

    typedef struct packed {
        logic            engage;
        logic            passthrough;
        t_decision       rate_class;
        logic [IV_W-1:0] measured_interval;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/prc_if.sv =====
// Valid/ready channel interfaces for present beats and result beats.
`timescale 1ns / 1ps
`default_nettype none

interface prc_in_if;
    logic                        valid;
    logic                        ready;
    logic [prc_pkg::TIME_W-1:0]  timestamp_ns;
    logic                        requested;

    modport source (output valid, output timestamp_ns, output requested, input ready);
    modport sink   (input valid, input timestamp_ns, input requested, output ready);
endinterface

interface prc_out_if;
    logic                      valid;
    logic                      ready;
    logic                      engage;
    logic                      passthrough;
    logic [1:0]                rate_class;
    logic [prc_pkg::IV_W-1:0]  measured_interval;

    modport source (output valid, output engage, output passthrough, output rate_class,
                    output measured_interval, input ready);
    modport sink   (input valid, input engage, input passthrough, input rate_class,
                    input measured_interval, output ready);
endinterface

`default_nettype wire

// ===== sv/present_rate_classifier_unit.sv =====
// Top level of the present rate classifier: channel registers and configuration.
`timescale 1ns / 1ps
`default_nettype none

// Present rate classifier. Each present beat (timestamp in ns, request flag)
// yields exactly one result beat: engage, passthrough, rate class and the
// valid interval measured on that present. A beat is captured in an input
// register, processed against the timing state (interval subtract and
// window check, Q27.3 average update, classification) and written to an
// output register; a beat stays in the input register while the output
// register holds an untaken result. One beat is taken every cycle as long
// as the result side keeps taking beats. Configuration registers are to be
// written over APB only while the block is idle; the block does not enforce
// this. SAMPLE_CAP sets where the sample counter saturates.

module present_rate_classifier_unit #(
    parameter int unsigned SAMPLE_CAP = 120
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [prc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [prc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [prc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    prc_in_if.sink                              i_in,
    prc_out_if.source                           o_out
);

    prc_pkg::t_cfg              w_cfg;
    prc_pkg::t_result           w_result;

    logic                       r_in_valid;
    logic [prc_pkg::TIME_W-1:0] r_in_time;
    logic                       r_in_req;
    logic                       r_out_valid;
    prc_pkg::t_result           r_out;
    logic                       w_step;

    prc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    prc_track #(
        .SAMPLE_CAP (SAMPLE_CAP)
    ) u_track (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (w_step),
        .i_timestamp_ns (r_in_time),
        .i_requested    (r_in_req),
        .i_cfg          (w_cfg),
        .o_result       (w_result)
    );

    // Process the held beat whenever the output slot is free or draining
    assign w_step     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_time <= i_in.timestamp_ns;
            r_in_req  <= i_in.requested;
        end
    end

    // Output register: load on step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.engage            = r_out.engage;
    assign o_out.passthrough       = r_out.passthrough;
    assign o_out.rate_class        = r_out.rate_class;
    assign o_out.measured_interval = r_out.measured_interval;

    // Passthrough only in high-rate mode
    a_pt_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.passthrough) |-> (r_out.rate_class == prc_pkg::DEC_HIGH))
        else $error("passthrough outside high-rate mode");

    // Generation only in low-rate mode
    a_engage_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.engage) |-> (r_out.rate_class == prc_pkg::DEC_LOW))
        else $error("engage outside low-rate mode");

    // A processed beat always lands in the output register
    a_step_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step |=> r_out_valid)
        else $error("processed beat lost");

endmodule

`default_nettype wire

// ===== sv/prc_regs.sv =====
// APB configuration register file of the present rate classifier.
`timescale 1ns / 1ps
`default_nettype none

module prc_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [prc_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [prc_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [prc_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    output prc_pkg::t_cfg                       o_cfg
);

    prc_pkg::t_cfg      r_cfg;
    prc_pkg::t_reg_idx  w_idx;
    logic               w_wr;

    assign w_idx  = prc_pkg::t_reg_idx'(paddr[prc_pkg::APB_ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Write the addressed register on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval_ns    <= prc_pkg::RST_MIN_INTERVAL;
            r_cfg.max_interval_ns    <= prc_pkg::RST_MAX_INTERVAL;
            r_cfg.high_rate_limit_ns <= prc_pkg::RST_HIGH_RATE_LIM;
            r_cfg.slow_interval_ns   <= prc_pkg::RST_SLOW_INTERVAL;
            r_cfg.min_samples        <= prc_pkg::RST_MIN_SAMPLES;
            r_cfg.slow_run_limit     <= prc_pkg::RST_SLOW_RUN_LIM;
        end else if (w_wr) begin
            case (w_idx)
                prc_pkg::REG_MIN_INTERVAL: begin
                    r_cfg.min_interval_ns <= pwdata[prc_pkg::IV_W-1:0];
                end
                prc_pkg::REG_MAX_INTERVAL: begin
                    r_cfg.max_interval_ns <= pwdata[prc_pkg::IV_W-1:0];
                end
                prc_pkg::REG_HIGH_RATE_LIM: begin
                    r_cfg.high_rate_limit_ns <= pwdata[prc_pkg::IV_W-1:0];
                end
                prc_pkg::REG_SLOW_INTERVAL: begin
                    r_cfg.slow_interval_ns <= pwdata[prc_pkg::IV_W-1:0];
                end
                prc_pkg::REG_MIN_SAMPLES: begin
                    r_cfg.min_samples <= pwdata[prc_pkg::COUNT_W-1:0];
                end
                prc_pkg::REG_SLOW_RUN_LIM: begin
                    r_cfg.slow_run_limit <= pwdata[prc_pkg::RUN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back the addressed register, zero extended
    always_comb begin
        prdata = '0;
        case (w_idx)
            prc_pkg::REG_MIN_INTERVAL: begin
                prdata[prc_pkg::IV_W-1:0] = r_cfg.min_interval_ns;
            end
            prc_pkg::REG_MAX_INTERVAL: begin
                prdata[prc_pkg::IV_W-1:0] = r_cfg.max_interval_ns;
            end
            prc_pkg::REG_HIGH_RATE_LIM: begin
                prdata[prc_pkg::IV_W-1:0] = r_cfg.high_rate_limit_ns;
            end
            prc_pkg::REG_SLOW_INTERVAL: begin
                prdata[prc_pkg::IV_W-1:0] = r_cfg.slow_interval_ns;
            end
            prc_pkg::REG_MIN_SAMPLES: begin
                prdata[prc_pkg::COUNT_W-1:0] = r_cfg.min_samples;
            end
            prc_pkg::REG_SLOW_RUN_LIM: begin
                prdata[prc_pkg::RUN_W-1:0] = r_cfg.slow_run_limit;
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/prc_track.sv =====
// Interval measurement, running average and rate decision state.
`timescale 1ns / 1ps
`default_nettype none

module prc_track #(
    parameter int unsigned SAMPLE_CAP = 120
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_step,
    input  wire logic [prc_pkg::TIME_W-1:0] i_timestamp_ns,
    input  wire logic                       i_requested,
    input  prc_pkg::t_cfg                   i_cfg,
    output prc_pkg::t_result                o_result
);

    localparam logic [prc_pkg::COUNT_W-1:0] CAP = prc_pkg::COUNT_W'(SAMPLE_CAP);

    // Timing state
    logic [prc_pkg::TIME_W-1:0]  r_last_time, n_last_time;
    logic [prc_pkg::AVG_W-1:0]   r_avg, n_avg;
    logic [prc_pkg::COUNT_W-1:0] r_count, n_count;
    logic [prc_pkg::RUN_W-1:0]   r_slow_run, n_slow_run;
    logic                        r_prev_req, n_prev_req;
    prc_pkg::t_decision          r_decision, n_decision;
    logic                        r_pt_flag, n_pt_flag;

    logic [prc_pkg::TIME_W-1:0]  w_diff;
    logic                        w_observe;
    logic                        w_sample;
    logic [prc_pkg::IV_W-1:0]    w_iv;
    logic [prc_pkg::AVG_W+2:0]   w_avg7;
    logic [prc_pkg::AVG_W-1:0]   w_avg_upd;
    logic [prc_pkg::AVG_W-1:0]   w_avg_obs;
    logic [prc_pkg::COUNT_W-1:0] w_count_obs;
    logic                        w_enough;
    prc_pkg::t_decision          w_class;
    logic                        w_engage;

    // Measure the interval; low rate while requested ignores timing
    assign w_diff    = i_timestamp_ns - r_last_time;
    assign w_observe = !i_requested || (r_decision != prc_pkg::DEC_LOW);
    assign w_sample  = w_observe && (r_last_time != '0) && (i_timestamp_ns > r_last_time)
                     && (w_diff[prc_pkg::TIME_W-1:prc_pkg::IV_W] == '0)
                     && (w_diff[prc_pkg::IV_W-1:0] >= i_cfg.min_interval_ns)
                     && (w_diff[prc_pkg::IV_W-1:0] <= i_cfg.max_interval_ns);
    assign w_iv      = w_sample ? w_diff[prc_pkg::IV_W-1:0] : '0;

    // Average: 7/8 of the old value rounded half up, plus the new interval; the first sample sets it directly
    assign w_avg7    = ({3'b000, r_avg} << 3) - {3'b000, r_avg} + (prc_pkg::AVG_W+3)'(4);
    assign w_avg_upd = w_avg7[prc_pkg::AVG_W+2:3] + {3'b000, w_iv};
    assign w_avg_obs = !w_sample ? r_avg
                     : (r_count == '0) ? {w_iv, 3'b000} : w_avg_upd;
    assign w_count_obs = (w_sample && (r_count < CAP)) ? r_count + 1'b1 : r_count;

    // Classify from the updated average and count
    assign w_enough = w_count_obs >= i_cfg.min_samples;
    assign w_class  = (w_enough && (w_avg_obs != '0)
                      && (w_avg_obs < {i_cfg.high_rate_limit_ns, 3'b000}))
                    ? prc_pkg::DEC_HIGH : prc_pkg::DEC_LOW;

    // Request edges, decision and slow run
    always_comb begin
        n_last_time = w_observe ? i_timestamp_ns : r_last_time;
        n_avg       = w_avg_obs;
        n_count     = w_count_obs;
        n_slow_run  = r_slow_run;
        n_prev_req  = r_prev_req;
        n_decision  = r_decision;
        n_pt_flag   = r_pt_flag;
        w_engage    = 1'b0;

        if (i_requested != r_prev_req) begin
            if (i_requested) begin
                n_decision = w_enough ? w_class : prc_pkg::DEC_UND;
            end else begin
                n_last_time = '0;
                n_avg       = '0;
                n_count     = '0;
                n_decision  = prc_pkg::DEC_UND;
                n_pt_flag   = 1'b0;
            end
            n_slow_run = '0;
            n_prev_req = i_requested;
        end

        if (!i_requested) begin
            n_pt_flag = 1'b0;
        end else begin
            if ((n_decision == prc_pkg::DEC_UND) && w_enough) begin
                n_decision = w_class;
            end
            if (n_decision == prc_pkg::DEC_HIGH) begin
                n_pt_flag = 1'b1;
                if (w_iv >= i_cfg.slow_interval_ns) begin
                    if (n_slow_run != prc_pkg::SLOW_RUN_MAX) begin
                        n_slow_run = n_slow_run + 1'b1;
                    end
                end else if (w_iv != '0) begin
                    n_slow_run = '0;
                end
                // Drop to low rate after a long enough slow run
                if (n_slow_run >= i_cfg.slow_run_limit) begin
                    n_decision = prc_pkg::DEC_LOW;
                    n_slow_run = '0;
                end
            end
            if (n_decision == prc_pkg::DEC_LOW) begin
                n_pt_flag = 1'b0;
                w_engage  = 1'b1;
            end
        end
    end

    assign o_result.engage            = w_engage;
    assign o_result.passthrough       = i_requested & n_pt_flag;
    assign o_result.rate_class        = n_decision;
    assign o_result.measured_interval = w_iv;

    // Advance state once per processed beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_time <= '0;
            r_avg       <= '0;
            r_count     <= '0;
            r_slow_run  <= '0;
            r_prev_req  <= 1'b0;
            r_decision  <= prc_pkg::DEC_UND;
            r_pt_flag   <= 1'b0;
        end else if (i_step) begin
            r_last_time <= n_last_time;
            r_avg       <= n_avg;
            r_count     <= n_count;
            r_slow_run  <= n_slow_run;
            r_prev_req  <= n_prev_req;
            r_decision  <= n_decision;
            r_pt_flag   <= n_pt_flag;
        end
    end

endmodule

`default_nettype wire
